/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define AUS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define AUS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define AUS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/aus_pkg.sv */
package aus_pkg;

    localparam int LengthBits    = 32;
    localparam int LengthOutBits = 32;
    localparam int FifoDepth     = 4;
    localparam int FifoAddrBits  = $clog2(FifoDepth);
    localparam int FifoCountBits = $clog2(FifoDepth + 1);

    localparam logic [31:0] StartCode   = 32'h0000_0001;
    localparam logic [2:0]  WindowBytes = 3'd4;

    localparam logic [LengthBits-1:0] HeaderLag = LengthBits'(5);

    typedef logic [5:0] nal_entry_t;

    localparam nal_entry_t NalInvalid = 6'h20;
    localparam nal_entry_t NalIdr     = 6'd5;
    localparam nal_entry_t NalSps     = 6'd7;
    localparam nal_entry_t NalPps     = 6'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } stream_item_t;

    typedef struct packed {
        logic [LengthOutBits-1:0] frame_length;
        logic                     final_piece;
    } piece_item_t;

    typedef struct packed {
        logic        first_valid;
        logic        second_valid;
        piece_item_t first;
        piece_item_t second;
    } piece_push_t;

endpackage

/* hw/rtl/h264_access_unit_size_splitter_unit.sv */
// Splits an H.264 Annex B byte stream into frame lengths.
// The stream channel (stream_valid, stream_stall, stream_item) carries one byte per
// transfer together with an end_of_stream flag on the last byte.
// The piece channel (piece_valid, piece_stall, piece_item) carries one frame length per
// transfer; final_piece marks the closing length sent at the end of the stream.
// One byte can be taken every cycle. A byte causes zero, one or two results, and a
// result is in the buffer in the cycle after its byte and is sent in buffer order.
// Results wait in a four-entry buffer. The stream side is stalled while fewer than
// two entries are free, so the rate drops below one byte per cycle only while the
// receiver stalls or a byte yields two results faster than they drain.
// Once piece_valid is high, it and the head result hold while the receiver stalls.
// Reset clears the start-code window, byte count, frame start and NAL type history
// and empties the buffer, so stream_stall is low once reset is released.
// After the last byte of a stream the same parser state returns, though the buffer
// keeps its results, so the next byte begins a new stream.
module h264_access_unit_size_splitter_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 stream_valid,
    output logic                 stream_stall,
    input  aus_pkg::stream_item_t stream_item,
    output logic                 piece_valid,
    input  logic                 piece_stall,
    output aus_pkg::piece_item_t  piece_item
);
    import aus_pkg::*;

    logic        accept;
    logic        room;
    piece_push_t push;

    assign stream_stall = !room;
    assign accept       = stream_valid && room;

    aus_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (stream_item),
        .push   (push)
    );

    aus_out_fifo u_out_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .room        (room),
        .piece_valid (piece_valid),
        .piece_stall (piece_stall),
        .piece_item  (piece_item)
    );

endmodule

/* hw/rtl/aus_parser.sv */
`include "assert_macros.svh"

module aus_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  aus_pkg::stream_item_t item,
    output aus_pkg::piece_push_t  push
);
    import aus_pkg::*;

    logic [31:0]           byte_window_reg;
    logic [31:0]           byte_window_next;
    logic [2:0]            window_fill_reg;
    logic [2:0]            window_fill_next;
    logic                  header_pending_reg;
    logic                  header_pending_next;
    logic [LengthBits-1:0] byte_position_reg;
    logic [LengthBits-1:0] byte_position_next;
    logic [LengthBits-1:0] frame_start_reg;
    logic [LengthBits-1:0] frame_start_next;
    nal_entry_t            type_history_reg [3];
    nal_entry_t            type_history_next [3];

    logic [LengthBits-1:0] pos_inc;
    logic [LengthBits-1:0] code_at;
    logic                  sps_pps_pair;
    logic                  frame_ends;
    piece_item_t           closing;

    function automatic logic [LengthBits-1:0] span(
        input logic [LengthBits-1:0] to_pos,
        input logic [LengthBits-1:0] from_pos
    );
        return (to_pos >= from_pos) ? (to_pos - from_pos) : '0;
    endfunction

    // The newest history entry is index 2.
    always_comb
    begin
        pos_inc = (byte_position_reg != '1) ? (byte_position_reg + LengthBits'(1))
                                            : byte_position_reg;
        code_at = (pos_inc >= HeaderLag) ? (pos_inc - HeaderLag) : '0;

        sps_pps_pair = (type_history_reg[0] == NalSps && type_history_reg[1] == NalPps) ||
                       (type_history_reg[0] == NalPps && type_history_reg[1] == NalSps);
        frame_ends = (sps_pps_pair && type_history_reg[2] == NalIdr) ||
                     (!type_history_reg[2][5] && type_history_reg[2] != '0 &&
                      type_history_reg[2] != NalIdr && type_history_reg[2] != NalSps &&
                      type_history_reg[2] != NalPps);

        byte_window_next    = byte_window_reg;
        window_fill_next    = window_fill_reg;
        header_pending_next = header_pending_reg;
        byte_position_next  = byte_position_reg;
        frame_start_next    = frame_start_reg;
        for (int i = 0; i < 3; i++)
        begin
            type_history_next[i] = type_history_reg[i];
        end
        push    = '0;
        closing = '0;

        if (accept)
        begin
            byte_position_next = pos_inc;
            if (header_pending_reg)
            begin
                if (frame_ends)
                begin
                    push.first_valid        = 1'b1;
                    push.first.frame_length = LengthOutBits'(span(code_at, frame_start_reg));
                    push.first.final_piece  = 1'b0;
                    frame_start_next        = code_at;
                end
                type_history_next[0] = type_history_reg[1];
                type_history_next[1] = type_history_reg[2];
                type_history_next[2] = {1'b0, item.data_byte[4:0]};
                header_pending_next  = 1'b0;
                byte_window_next     = '0;
                window_fill_next     = '0;
            end
            else
            begin
                byte_window_next = {byte_window_reg[23:0], item.data_byte};
                if (window_fill_reg < WindowBytes)
                begin
                    window_fill_next = window_fill_reg + 3'd1;
                end
                if (window_fill_next == WindowBytes && byte_window_next == StartCode)
                begin
                    header_pending_next = 1'b1;
                end
            end

            if (item.end_of_stream)
            begin
                closing.frame_length = LengthOutBits'(span(pos_inc, frame_start_next));
                closing.final_piece  = 1'b1;
                if (push.first_valid)
                begin
                    push.second_valid = 1'b1;
                    push.second       = closing;
                end
                else
                begin
                    push.first_valid = 1'b1;
                    push.first       = closing;
                end

                // The stream is over, so the next byte starts a fresh one.
                byte_window_next    = '0;
                window_fill_next    = '0;
                header_pending_next = 1'b0;
                byte_position_next  = '0;
                frame_start_next    = '0;
                for (int i = 0; i < 3; i++)
                begin
                    type_history_next[i] = NalInvalid;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_window_reg    <= '0;
            window_fill_reg    <= '0;
            header_pending_reg <= 1'b0;
            byte_position_reg  <= '0;
            frame_start_reg    <= '0;
            for (int i = 0; i < 3; i++)
            begin
                type_history_reg[i] <= NalInvalid;
            end
        end
        else
        begin
            byte_window_reg    <= byte_window_next;
            window_fill_reg    <= window_fill_next;
            header_pending_reg <= header_pending_next;
            byte_position_reg  <= byte_position_next;
            frame_start_reg    <= frame_start_next;
            for (int i = 0; i < 3; i++)
            begin
                type_history_reg[i] <= type_history_next[i];
            end
        end
    end

    `AUS_ASSERT_IMPL(a_pending_has_code, header_pending_reg,
        window_fill_reg == WindowBytes && byte_window_reg == StartCode,
        "Header pending without a start code in the window.")
    `AUS_ASSERT(a_start_before_pos, frame_start_reg <= byte_position_reg,
        "Frame start lies beyond the byte position.")
    `AUS_ASSERT(a_fill_range, window_fill_reg <= WindowBytes,
        "Window fill count out of range.")
    `AUS_ASSERT_IMPL(a_second_is_final, push.second_valid,
        push.first_valid && push.second.final_piece && !push.first.final_piece,
        "Second result must be the closing length after a frame length.")

endmodule

/* hw/rtl/aus_out_fifo.sv */
`include "assert_macros.svh"

module aus_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  aus_pkg::piece_push_t push,
    output logic                room,
    output logic                piece_valid,
    input  logic                piece_stall,
    output aus_pkg::piece_item_t piece_item
);
    import aus_pkg::*;

    piece_item_t              mem [FifoDepth];
    logic [FifoAddrBits-1:0]  wr_ptr_reg;
    logic [FifoAddrBits-1:0]  wr_ptr_next;
    logic [FifoAddrBits-1:0]  rd_ptr_reg;
    logic [FifoAddrBits-1:0]  rd_ptr_next;
    logic [FifoCountBits-1:0] count_reg;
    logic [FifoCountBits-1:0] count_next;
    logic [FifoCountBits-1:0] push_count;
    logic                     pop;
    logic                     push_any;

    always_comb
    begin
        push_count  = FifoCountBits'(push.first_valid) + FifoCountBits'(push.second_valid);
        push_any    = push.first_valid || push.second_valid;
        pop         = (count_reg != '0) && !piece_stall;
        wr_ptr_next = wr_ptr_reg + FifoAddrBits'(push_count);
        rd_ptr_next = rd_ptr_reg + FifoAddrBits'(pop);
        count_next  = count_reg + push_count - FifoCountBits'(pop);
    end

    assign room        = count_reg <= FifoCountBits'(FifoDepth - 2);
    assign piece_valid = count_reg != '0;
    assign piece_item  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.first_valid)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.second_valid)
        begin
            mem[wr_ptr_reg + FifoAddrBits'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `AUS_ASSERT(a_count_range, count_reg <= FifoCountBits'(FifoDepth),
        "Result buffer count exceeds its depth.")
    `AUS_ASSERT_IMPL(a_push_has_room, push_any,
        count_reg <= FifoCountBits'(FifoDepth - 2),
        "Results written without room for two entries.")
    `AUS_ASSERT_NEXT(a_pop_drains, pop && !push_any,
        count_reg == $past(count_reg) - FifoCountBits'(1),
        "Count did not drop after a transfer with no new results.")

endmodule
